// File: src/frt_pkg.sv
// shared types, constants and codes for the fragment reassembly timeout unit
// no dependencies; used by every module of the block except frt_ram
package frt_pkg;

    localparam int SLOT_COUNT_DEFAULT = 10;
    localparam int FRAME_BYTES        = 32;
    localparam int HEADER_BYTES       = 3;
    localparam int PAYLOAD_MAX        = FRAME_BYTES - HEADER_BYTES;
    localparam int PAYLOAD_BYTES      = 29;
    localparam int PAYLOAD_W          = PAYLOAD_BYTES * 8;
    localparam int SIZE_W             = 5;
    localparam int IDLE_W             = 17;
    localparam int TIMEOUT_W          = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    typedef enum logic [0:0] {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        KIND_STATUS = 1'b0,
        KIND_FRAG   = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_STORED    = 3'd0,
        STATUS_INVALID   = 3'd1,
        STATUS_IGNORED   = 3'd2,
        STATUS_TICK_IDLE = 3'd3,
        STATUS_TIMEOUT   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_TIMEOUT_TICKS = 1'b0
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        opcode_t      opcode;
        logic [7:0]   frag_index;
        logic [7:0]   frag_total;
        logic [7:0]   payload_size;
        logic [63:0]  payload_w0;
        logic [63:0]  payload_w1;
        logic [63:0]  payload_w2;
        logic [39:0]  payload_w3;
    } in_item_t;

    typedef struct packed {
        kind_t        kind;
        status_t      status;
        logic [3:0]   out_index;
        logic [4:0]   out_size;
        logic [63:0]  out_w0;
        logic [63:0]  out_w1;
        logic [63:0]  out_w2;
        logic [39:0]  out_w3;
        logic         last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic in_load;
        logic eval_commit;
        logic rd_start;
        logic frag_commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic complete;
        logic last_slot;
    } stat_t;

endpackage

// File: src/frt_ram.sv
// generic single write port ram with registered read
// no dependencies
module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/frt_ctrl.sv
// sequencing state machine for the fragment reassembly timeout unit
// depends on frt_pkg for the state type and command/status structs
module frt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  frt_pkg::stat_t stat,
    output frt_pkg::cmd_t  cmd
);

    frt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            frt_pkg::ST_IDLE: begin
                if (s_valid) state_next = frt_pkg::ST_EVAL;
            end
            frt_pkg::ST_EVAL: begin
                if (stat.out_free) begin
                    state_next = stat.complete ? frt_pkg::ST_READ : frt_pkg::ST_IDLE;
                end
            end
            frt_pkg::ST_READ: begin
                state_next = frt_pkg::ST_LOAD;
            end
            frt_pkg::ST_LOAD: begin
                if (stat.out_free) begin
                    state_next = stat.last_slot ? frt_pkg::ST_IDLE : frt_pkg::ST_READ;
                end
            end
            default: state_next = frt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            frt_pkg::ST_IDLE: begin
                // nothing is taken while reset is held
                s_ready     = aresetn;
                cmd.in_load = s_valid && aresetn;
            end
            frt_pkg::ST_EVAL: begin
                cmd.eval_commit = stat.out_free;
            end
            frt_pkg::ST_READ: begin
                cmd.rd_start = 1'b1;
            end
            frt_pkg::ST_LOAD: begin
                cmd.frag_commit = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: src/frt_datapath.sv
// input register, reassembly state, fragment store and result register
// depends on frt_pkg and frt_ram
module frt_datapath #(
    parameter int SLOT_COUNT = frt_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  frt_pkg::cmd_t                     cmd,
    output frt_pkg::stat_t                    stat,
    input  frt_pkg::in_item_t                 s_data,
    input  logic [frt_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    output logic                              m_valid,
    input  logic                              m_ready,
    output frt_pkg::out_item_t                m_data
);

    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ENTRY_W  = frt_pkg::PAYLOAD_W + frt_pkg::SIZE_W;
    localparam logic [frt_pkg::IDLE_W-1:0] IDLE_MAX = '1;

    frt_pkg::in_item_t               in_reg;
    logic [SLOT_COUNT-1:0]           map_reg;
    logic [CNT_W-1:0]                expected_reg;
    logic [frt_pkg::IDLE_W-1:0]      idle_reg;
    logic [IDX_W-1:0]                slot_reg;
    logic                            m_valid_reg;
    frt_pkg::out_item_t              m_data_reg;

    logic                            is_tick;
    logic                            invalid;
    logic                            ignored;
    logic                            do_store;
    logic                            timed_out;
    logic [CNT_W-1:0]                exp_next;
    logic [frt_pkg::IDLE_W-1:0]      idle_inc;
    logic [SLOT_COUNT-1:0]           map_set;
    logic [SLOT_COUNT-1:0]           low_mask;
    logic                            complete;
    frt_pkg::status_t                eval_status;
    logic [frt_pkg::PAYLOAD_W-1:0]   payload_raw;
    logic [frt_pkg::PAYLOAD_W-1:0]   payload_masked;
    logic [ENTRY_W-1:0]              ram_wdata;
    logic [ENTRY_W-1:0]              ram_rdata;
    logic                            out_free;
    logic                            last_slot;
    frt_pkg::out_item_t              status_item;
    frt_pkg::out_item_t              frag_item;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_reg <= s_data;
        end
    end

    // frame decode
    always_comb begin
        is_tick   = (in_reg.opcode == frt_pkg::OP_TICK);
        invalid   = (in_reg.frag_total > 8'(SLOT_COUNT))
                 || (in_reg.payload_size > 8'(frt_pkg::PAYLOAD_MAX));
        exp_next  = (expected_reg == '0) ? in_reg.frag_total[CNT_W-1:0] : expected_reg;
        ignored   = (in_reg.frag_index >= in_reg.frag_total);
        do_store  = !is_tick && !invalid && !ignored;
        idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
        timed_out = (expected_reg != '0)
                 && (idle_inc > {1'b0, timeout_ticks});
        for (int i = 0; i < SLOT_COUNT; i++) begin
            map_set[i]  = map_reg[i] || (in_reg.frag_index == 8'(i));
            low_mask[i] = (CNT_W'(i) < exp_next);
        end
        complete = do_store && (exp_next != '0) && ((map_set & low_mask) == low_mask);
        if (is_tick) begin
            eval_status = timed_out ? frt_pkg::STATUS_TIMEOUT : frt_pkg::STATUS_TICK_IDLE;
        end else if (invalid) begin
            eval_status = frt_pkg::STATUS_INVALID;
        end else if (ignored) begin
            eval_status = frt_pkg::STATUS_IGNORED;
        end else begin
            eval_status = frt_pkg::STATUS_STORED;
        end
    end

    // zero payload bytes at or above the fragment size
    always_comb begin
        payload_raw = {in_reg.payload_w3, in_reg.payload_w2,
                       in_reg.payload_w1, in_reg.payload_w0};
        for (int b = 0; b < frt_pkg::PAYLOAD_BYTES; b++) begin
            payload_masked[b*8 +: 8] = (in_reg.payload_size > 8'(b))
                                     ? payload_raw[b*8 +: 8] : 8'h00;
        end
        ram_wdata = {in_reg.payload_size[frt_pkg::SIZE_W-1:0], payload_masked};
    end

    frt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(IDX_W)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.eval_commit && do_store),
        .waddr(in_reg.frag_index[IDX_W-1:0]),
        .wdata(ram_wdata),
        .re   (cmd.rd_start),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    assign last_slot = ((CNT_W'(slot_reg) + 1'b1) == expected_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // reassembly state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg      <= '0;
            expected_reg <= '0;
            idle_reg     <= '0;
        end else if (cmd.eval_commit) begin
            if (is_tick) begin
                idle_reg <= idle_inc;
                if (timed_out) begin
                    map_reg      <= '0;
                    expected_reg <= '0;
                end
            end else if (!invalid) begin
                expected_reg <= exp_next;
                if (!ignored) begin
                    idle_reg <= '0;
                    map_reg  <= map_set;
                end
            end
        end else if (cmd.frag_commit && last_slot) begin
            map_reg      <= '0;
            expected_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (cmd.eval_commit) begin
            slot_reg <= '0;
        end else if (cmd.frag_commit) begin
            slot_reg <= slot_reg + 1'b1;
        end
    end

    // result items
    always_comb begin
        status_item        = '0;
        status_item.kind   = frt_pkg::KIND_STATUS;
        status_item.status = eval_status;
        status_item.last   = !complete;

        frag_item.kind      = frt_pkg::KIND_FRAG;
        frag_item.status    = frt_pkg::STATUS_STORED;
        frag_item.out_index = 4'(slot_reg);
        frag_item.out_size  = ram_rdata[ENTRY_W-1 -: frt_pkg::SIZE_W];
        frag_item.out_w0    = ram_rdata[63:0];
        frag_item.out_w1    = ram_rdata[127:64];
        frag_item.out_w2    = ram_rdata[191:128];
        frag_item.out_w3    = ram_rdata[231:192];
        frag_item.last      = last_slot;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.eval_commit || cmd.frag_commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval_commit) begin
            m_data_reg <= status_item;
        end else if (cmd.frag_commit) begin
            m_data_reg <= frag_item;
        end
    end

    assign stat.out_free  = out_free;
    assign stat.complete  = complete;
    assign stat.last_slot = last_slot;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

endmodule

// File: src/fragment_reassembly_timeout_unit.sv
// top level of the fragment reassembly timeout unit: apb register and hookup
// depends on frt_pkg, frt_ctrl, frt_datapath (and frt_ram below it)
//
// usage
//   s_ channel: one request per item, either a received fragment frame or a
//   single tick (opcode). m_ channel: result items, a status item for every
//   request, followed by one item per fragment, in index order, when the
//   request completes a message; last marks the final item of a request.
//   apb port: register 0 at byte address 0 is timeout_ticks (16 bits,
//   reset 1000); write it only while no request is in flight.
// sequence
//   a request is taken into the input register in IDLE and evaluated in
//   EVAL once the result register is free; the status item is loaded into
//   the result register at evaluation. a completing request then reads the
//   store ram, one slot per read and load pair: each fragment needs a
//   registered store read in READ, then a load of the result register in
//   LOAD, which waits until the result register is free.
// reset and stall
//   synchronous active-low reset clears the received map, expected count,
//   idle counter and result valid; no request is taken while reset is held.
//   store contents are not cleared and are only read for slots marked
//   received. a stalled receiver holds the result register, and the unit
//   waits until it is taken before the next result.
module fragment_reassembly_timeout_unit #(
    parameter int SLOT_COUNT = frt_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  frt_pkg::in_item_t                 s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output frt_pkg::out_item_t                m_data,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [frt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [frt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [frt_pkg::TIMEOUT_W-1:0] timeout_reg;
    frt_pkg::cmd_t                 cmd;
    frt_pkg::stat_t                stat;
    logic                          wr_en;
    frt_pkg::reg_index_t           reg_sel;

    // word index of the access, low address bits ignored
    assign reg_sel = frt_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= frt_pkg::TIMEOUT_RESET;
        end else if (wr_en && (reg_sel == frt_pkg::REG_TIMEOUT_TICKS)) begin
            timeout_reg <= pwdata[frt_pkg::TIMEOUT_W-1:0];
        end
    end

    // read back, unmapped addresses read zero
    always_comb begin
        unique case (reg_sel)
            frt_pkg::REG_TIMEOUT_TICKS:
                prdata = {{(frt_pkg::APB_DATA_W - frt_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
            default: prdata = '0;
        endcase
    end

    // sequencing
    frt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // state, store and result register
    frt_datapath #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_data       (s_data),
        .timeout_ticks(timeout_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// File: sim/tb.sv
// self-checking testbench for fragment_reassembly_timeout_unit
// holds its own reassembly predictor and drives the s_/m_ channels and the apb port
// depends on frt_pkg and the rtl under src only
module tb;

    localparam int SLOTS         = frt_pkg::SLOT_COUNT_DEFAULT;
    localparam int CYCLE_LIMIT   = 2_000_000;
    // worst request: eval plus a read and load pair per slot, with margin
    localparam int SETTLE_CYCLES = 2 + 2 * SLOTS + 10;
    localparam logic [frt_pkg::IDLE_W-1:0]     IDLE_CEIL    = '1;
    localparam logic [frt_pkg::APB_ADDR_W-1:0] TIMEOUT_ADDR =
        frt_pkg::APB_ADDR_W'(int'(frt_pkg::REG_TIMEOUT_TICKS) * 4);

    // clock, reset and block ports; the inputs driven here are known from time zero
    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    frt_pkg::in_item_t              s_data  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    frt_pkg::out_item_t             m_data;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [frt_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [frt_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [frt_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // run bookkeeping
    int cycle_count    = 0;
    int mismatch_count = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;

    // predictor state: a private copy of the reassembly store and counters
    logic [63:0]                   slot_word [SLOTS][4];
    logic [frt_pkg::SIZE_W-1:0]    slot_size [SLOTS];
    logic [SLOTS-1:0]              slot_seen;
    logic [3:0]                    msg_total;
    logic [frt_pkg::IDLE_W-1:0]    idle_count;
    logic [frt_pkg::TIMEOUT_W-1:0] timeout_limit;

    // results still owed by the block, oldest first
    frt_pkg::out_item_t due_items [$];

    fragment_reassembly_timeout_unit #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // keeps the payload bytes below size that fall in 64-bit word number word
    function automatic logic [63:0] keep_mask(int size, int word);
        int lo;
        int n;
        lo = word * 8;
        if (size <= lo) return 64'd0;
        n = size - lo;
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // sizes, received map and latched total go back to zero; payload words stay
    function automatic void clear_slots();
        for (int i = 0; i < SLOTS; i++) slot_size[i] = '0;
        slot_seen = '0;
        msg_total = '0;
    endfunction

    function automatic frt_pkg::out_item_t status_item(frt_pkg::status_t code, logic fin);
        frt_pkg::out_item_t r;
        r        = '0;
        r.kind   = frt_pkg::KIND_STATUS;
        r.status = code;
        r.last   = fin;
        return r;
    endfunction

    // works out every result of one accepted request and queues them in order
    function automatic void reassemble_step(frt_pkg::in_item_t req);
        frt_pkg::out_item_t r;
        int                 idx;
        int                 total;
        int                 size;
        logic [15:0]        need;
        logic               complete;
        idx   = req.frag_index;
        total = req.frag_total;
        size  = req.payload_size;

        if (req.opcode == frt_pkg::OP_TICK) begin
            // saturating idle counter; a pending message times out above the limit
            if (idle_count != IDLE_CEIL) idle_count = idle_count + 1'b1;
            if (msg_total != 0 && idle_count > timeout_limit) begin
                clear_slots();
                due_items.push_back(status_item(frt_pkg::STATUS_TIMEOUT, 1'b1));
            end else begin
                due_items.push_back(status_item(frt_pkg::STATUS_TICK_IDLE, 1'b1));
            end
            return;
        end

        if (total > SLOTS || size > frt_pkg::PAYLOAD_MAX) begin
            due_items.push_back(status_item(frt_pkg::STATUS_INVALID, 1'b1));
            return;
        end
        // the total latches even when the index is then ignored
        if (msg_total == 0) msg_total = 4'(total);
        if (idx >= total) begin
            due_items.push_back(status_item(frt_pkg::STATUS_IGNORED, 1'b1));
            return;
        end

        idle_count     = '0;
        slot_seen[idx] = 1'b1;
        slot_size[idx] = frt_pkg::SIZE_W'(size);
        slot_word[idx][0] = req.payload_w0 & keep_mask(size, 0);
        slot_word[idx][1] = req.payload_w1 & keep_mask(size, 1);
        slot_word[idx][2] = req.payload_w2 & keep_mask(size, 2);
        slot_word[idx][3] = {24'd0, req.payload_w3} & keep_mask(size, 3);

        // completion only looks at the slots below the latched total
        need     = (16'd1 << msg_total) - 16'd1;
        complete = (msg_total != 0) && ((16'(slot_seen) & need) == need);
        due_items.push_back(status_item(frt_pkg::STATUS_STORED, !complete));
        if (complete) begin
            for (int i = 0; i < msg_total; i++) begin
                r           = '0;
                r.kind      = frt_pkg::KIND_FRAG;
                r.status    = frt_pkg::STATUS_STORED;
                r.out_index = 4'(i);
                r.out_size  = slot_size[i];
                r.out_w0    = slot_word[i][0];
                r.out_w1    = slot_word[i][1];
                r.out_w2    = slot_word[i][2];
                r.out_w3    = slot_word[i][3][39:0];
                r.last      = (i == msg_total - 1);
                due_items.push_back(r);
            end
            clear_slots();
        end
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result(frt_pkg::out_item_t got);
        frt_pkg::out_item_t want;
        if (due_items.size() == 0) begin
            report_mismatch("result with no request waiting");
            return;
        end
        want = due_items.pop_front();
        check_field("kind",      got.kind,      want.kind);
        check_field("status",    got.status,    want.status);
        check_field("out_index", got.out_index, want.out_index);
        check_field("out_size",  got.out_size,  want.out_size);
        check_field("out_w0",    got.out_w0,    want.out_w0);
        check_field("out_w1",    got.out_w1,    want.out_w1);
        check_field("out_w2",    got.out_w2,    want.out_w2);
        check_field("out_w3",    got.out_w3,    want.out_w3);
        check_field("last",      got.last,      want.last);
    endtask

    // every taken result is compared with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result(m_data);
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // offers one request, holds it until taken, then predicts its results
    task automatic send_request(frt_pkg::in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        reassemble_step(req);
        requests_sent++;
    endtask

    function automatic frt_pkg::in_item_t make_frame(int idx, int total, int size);
        frt_pkg::in_item_t req;
        req.opcode       = frt_pkg::OP_FRAME;
        req.frag_index   = 8'(idx);
        req.frag_total   = 8'(total);
        req.payload_size = 8'(size);
        req.payload_w0   = {$urandom, $urandom};
        req.payload_w1   = {$urandom, $urandom};
        req.payload_w2   = {$urandom, $urandom};
        req.payload_w3   = 40'({$urandom, $urandom});
        return req;
    endfunction

    task automatic send_frame(int idx, int total, int size);
        send_request(make_frame(idx, total, size));
    endtask

    // frame with every payload word set to one pattern
    task automatic send_filled(int idx, int total, int size, logic [63:0] fill);
        frt_pkg::in_item_t req;
        req            = make_frame(idx, total, size);
        req.payload_w0 = fill;
        req.payload_w1 = fill;
        req.payload_w2 = fill;
        req.payload_w3 = fill[39:0];
        send_request(req);
    endtask

    // header and payload of a tick are junk and must be ignored
    task automatic send_tick();
        frt_pkg::in_item_t req;
        req        = make_frame($urandom, $urandom, $urandom);
        req.opcode = frt_pkg::OP_TICK;
        send_request(req);
    endtask

    // any header at all: mostly rejected or ignored frames
    task automatic send_noise();
        int total;
        int size;
        total = $urandom_range(1) ? $urandom_range(255) : $urandom_range(SLOTS);
        size  = $urandom_range(1) ? $urandom_range(255)
                                  : $urandom_range(frt_pkg::PAYLOAD_MAX + 2);
        send_frame($urandom_range(255), total, size);
    endtask

    // lowers valid, waits for every owed result and lets the block go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_items.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------

    task automatic read_timeout_check(logic [frt_pkg::TIMEOUT_W-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("timeout_ticks readback", prdata[frt_pkg::TIMEOUT_W-1:0], want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only written with nothing in flight; upper data bits are junk
    task automatic write_timeout(logic [frt_pkg::TIMEOUT_W-1:0] value);
        settle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        timeout_limit = value;
        read_timeout_check(value);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_register_reset();
        read_timeout_check(frt_pkg::TIMEOUT_RESET);
    endtask

    task automatic test_directed_frames();
        send_tick();                                   // tick with nothing pending
        send_frame(0, SLOTS + 1, 5);                   // total one above the slot count
        send_frame(0, 3, frt_pkg::PAYLOAD_MAX + 1);    // payload one byte too long
        send_filled(255, 255, 255, '1);                // every header field at its top
        send_filled(0, 1, frt_pkg::PAYLOAD_MAX, '1);   // single fragment message, full size
        send_frame(5, 3, 7);                           // latches total 3, index ignored
        send_frame(2, 3, 0);                           // empty payload
        send_frame(7, 8, 12);                          // other total marks a slot above 3
        send_filled(0, 3, frt_pkg::PAYLOAD_MAX, '0);
        send_frame(1, 3, 17);                          // completes the three-slot message
        send_frame(0, 0, 4);                           // zero total latches nothing
        send_frame(255, SLOTS, frt_pkg::PAYLOAD_MAX);  // latches full total, index ignored
        // full message backwards, with slot 3 written twice
        for (int i = SLOTS - 1; i >= 1; i--)
            send_frame(i, SLOTS, $urandom_range(frt_pkg::PAYLOAD_MAX));
        send_frame(3, SLOTS, $urandom_range(frt_pkg::PAYLOAD_MAX));
        send_frame(0, SLOTS, frt_pkg::PAYLOAD_MAX);
    endtask

    task automatic test_timeouts();
        // zero limit: first tick with a message pending clears it
        write_timeout('0);
        send_frame(0, 2, 3);
        send_tick();
        send_tick();
        // limit one: the second idle tick clears
        write_timeout(16'd1);
        send_frame(1, 3, 9);
        send_tick();
        send_tick();
        send_frame(1, 2, 5);
        send_frame(0, 2, 6);
    endtask

    // one message in random order, with drops, duplicates, odd totals and ticks
    task automatic play_message();
        int order [SLOTS];
        int total;
        int j;
        int tmp;
        total = $urandom_range(1, SLOTS);
        for (int k = 0; k < SLOTS; k++) order[k] = k;
        for (int k = total - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < total; k++) begin
            if ($urandom_range(99) >= 8) begin
                if ($urandom_range(99) < 8)
                    send_frame(order[k], $urandom_range(1, SLOTS),
                               $urandom_range(frt_pkg::PAYLOAD_MAX));
                else
                    send_frame(order[k], total, $urandom_range(frt_pkg::PAYLOAD_MAX));
            end
            if ($urandom_range(99) < 10) send_tick();
            if ($urandom_range(99) < 5)
                send_frame(order[k], total, $urandom_range(frt_pkg::PAYLOAD_MAX));
            if ($urandom_range(99) < 4) send_noise();
        end
    endtask

    task automatic test_random_traffic(int count, int max_timeout);
        int goal;
        int pick;
        int span;
        write_timeout(frt_pkg::TIMEOUT_W'($urandom_range(1, max_timeout)));
        span = (timeout_limit < 10) ? timeout_limit + 2 : 12;
        goal = requests_sent + count;
        while (requests_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                play_message();
            end else if (pick < 80) begin
                // idle run that can be long enough to time out a pending message
                repeat ($urandom_range(1, span)) send_tick();
            end else begin
                send_noise();
            end
        end
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        settle();
        hold_left = 400;
        for (int i = 0; i < SLOTS; i++)
            send_frame(i, SLOTS, $urandom_range(frt_pkg::PAYLOAD_MAX));
        repeat (10) send_tick();
        send_frame(0, 1, frt_pkg::PAYLOAD_MAX);
    endtask

    // largest limit: ticks with a message pending do not clear it
    task automatic test_large_timeout();
        write_timeout('1);
        send_frame(0, 2, 8);
        repeat (4) send_tick();
        // an ignored frame while a total is already latched, then one more tick
        send_frame(5, 3, 1);
        send_tick();
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        for (int i = 0; i < SLOTS; i++)
            for (int w = 0; w < 4; w++) slot_word[i][w] = '0;
        clear_slots();
        idle_count    = '0;
        timeout_limit = frt_pkg::TIMEOUT_RESET;

        // single reset at the start of the run
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 20;
        recv_idle_pct = 54;
        test_register_reset();
        test_directed_frames();
        test_timeouts();
        test_random_traffic(40, 6);

        // the other way round
        settle();
        send_idle_pct = 54;
        recv_idle_pct = 20;
        test_random_traffic(40, 3);

        // no idling on either side
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(40, 12);
        test_backpressure();
        test_large_timeout();

        settle();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
